// ----- hw/rtl/kdf_pkg.sv -----
package kdf_pkg;

    // Default sizes, overridable on the top level.
    localparam int DEFAULT_FRAME_MAX      = 2048;
    localparam int DEFAULT_FRAGMENT_BYTES = 192;

    // Special bytes of the framing.
    localparam logic [7:0] FEND  = 8'hC0;
    localparam logic [7:0] FESC  = 8'hDB;
    localparam logic [7:0] TFEND = 8'hDC;
    localparam logic [7:0] TFESC = 8'hDD;

    // Command bytes.
    localparam logic [7:0] CMDB_DATA = 8'h00;
    localparam logic [7:0] CMDB_PERS = 8'h02;
    localparam logic [7:0] CMDB_SLOT = 8'h03;

    // Parser state codes.
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_CMD  = 3'd1;
    localparam logic [2:0] ST_DATA = 3'd2;
    localparam logic [2:0] ST_PERS = 3'd3;
    localparam logic [2:0] ST_SLOT = 3'd4;
    localparam logic [2:0] ST_ESC  = 3'd5;

    // Frame command codes.
    localparam logic [1:0] CMD_NONE = 2'd0;
    localparam logic [1:0] CMD_DATA = 2'd1;
    localparam logic [1:0] CMD_PERS = 2'd2;
    localparam logic [1:0] CMD_SLOT = 2'd3;

    // Result kinds.
    localparam logic [2:0] KIND_PAYLOAD = 3'd0;
    localparam logic [2:0] KIND_COMMIT  = 3'd1;
    localparam logic [2:0] KIND_DISCARD = 3'd2;
    localparam logic [2:0] KIND_PERS    = 3'd3;
    localparam logic [2:0] KIND_SLOT    = 3'd4;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  data_byte;
        logic [10:0] byte_position;
        logic [3:0]  fragment_number;
        logic [7:0]  fragment_offset;
        logic [11:0] frame_length;
        logic [7:0]  persistence;
        logic [11:0] slot_time_ms;
    } result_t;

endpackage

// ----- hw/rtl/kiss_deframer_fragmenter.sv -----
// Host-side decoder for the byte stream of the serial framing protocol.
// The slave channel takes one received serial byte per word in
// s_axis_tdata. The master channel gives at most one result word per input
// byte: m_axis_tuser carries the kind (payload byte, frame commit, frame
// discard, persistence set, slot time set) and m_axis_tdata the fields.
// Payload bytes are passed on at once, tagged with their position, fragment
// number and fragment offset; downstream buffers the frame and drops it on a
// discard word.
// An accepted byte is held in an input register, and the parser logic writes
// its result word into the output register, or into the skid stage if held.
// One byte is accepted in every cycle while the input is not stalled; the rate
// is set by the single parser state register, which is updated once per byte.
// Reset returns the parser to idle (waiting for a frame delimiter), empties
// the pipeline, sets persistence to 255 and slot time to zero.
// When the receiver stalls, result words are held in the output register and
// one skid stage; bytes that cause no result still flow through, and input
// is stalled once both stages are full and a byte that causes a result is
// waiting in the input register.
module kiss_deframer_fragmenter
    import kdf_pkg::*;
#(
    parameter int FRAME_MAX      = DEFAULT_FRAME_MAX,
    parameter int FRAGMENT_BYTES = DEFAULT_FRAGMENT_BYTES
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,  // [7:0] rx_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [7:0] data_byte, [18:8] byte_position, [22:19] fragment_number,
    // [30:23] fragment_offset, [42:31] frame_length, [50:43] persistence,
    // [62:51] slot_time_ms, [63] zero
    output logic [63:0] m_axis_tdata,
    output logic [2:0]  m_axis_tuser   // [2:0] kind
);

    logic    res_valid;
    logic    res_ready;
    result_t res;
    result_t out_res;

    kdf_parser #(
        .FRAME_MAX      (FRAME_MAX),
        .FRAGMENT_BYTES (FRAGMENT_BYTES)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_byte   (s_axis_tdata),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    kdf_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (res_valid),
        .in_ready  (res_ready),
        .in_res    (res),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_res   (out_res)
    );

    assign m_axis_tuser = out_res.kind;
    assign m_axis_tdata = {1'b0,
                           out_res.slot_time_ms,
                           out_res.persistence,
                           out_res.frame_length,
                           out_res.fragment_offset,
                           out_res.fragment_number,
                           out_res.byte_position,
                           out_res.data_byte};

endmodule

// ----- hw/rtl/kdf_parser.sv -----
module kdf_parser
    import kdf_pkg::*;
#(
    parameter int FRAME_MAX      = DEFAULT_FRAME_MAX,
    parameter int FRAGMENT_BYTES = DEFAULT_FRAGMENT_BYTES
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    output logic       res_valid,
    input  logic       res_ready,
    output result_t    res
);

    localparam int CW = $clog2(FRAME_MAX + 1);

    logic          s1_valid_reg;
    logic [7:0]    s1_byte_reg;

    logic [2:0]    state_reg, state_next;
    logic [1:0]    cmd_reg, cmd_next;
    logic [CW-1:0] count_reg, count_next;
    logic [3:0]    frag_num_reg, frag_num_next;
    logic [7:0]    frag_off_reg, frag_off_next;
    logic [7:0]    pers_reg, pers_next;
    logic [11:0]   slot_reg, slot_next;

    logic          emit;
    logic          store_en;
    logic [7:0]    store_byte;
    logic          advance;
    logic          clear_frame;

    always_comb
    begin
        state_next    = state_reg;
        cmd_next      = cmd_reg;
        count_next    = count_reg;
        frag_num_next = frag_num_reg;
        frag_off_next = frag_off_reg;
        pers_next     = pers_reg;
        slot_next     = slot_reg;
        emit          = 1'b0;
        store_en      = 1'b0;
        store_byte    = s1_byte_reg;
        clear_frame   = 1'b0;
        res           = '0;

        unique case (state_reg)
            ST_CMD:
            begin
                if (s1_byte_reg != FEND)
                begin
                    case (s1_byte_reg)
                        CMDB_DATA:
                        begin
                            cmd_next   = CMD_DATA;
                            state_next = ST_DATA;
                        end
                        CMDB_PERS:
                        begin
                            cmd_next   = CMD_PERS;
                            state_next = ST_PERS;
                        end
                        CMDB_SLOT:
                        begin
                            cmd_next   = CMD_SLOT;
                            state_next = ST_SLOT;
                        end
                        default:
                        begin
                            cmd_next   = CMD_NONE;
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_PERS:
            begin
                pers_next  = s1_byte_reg;
                state_next = ST_DATA;
                emit       = 1'b1;
                res.kind   = KIND_PERS;
            end
            ST_SLOT:
            begin
                // Byte times ten as eight times plus two times.
                slot_next  = {1'b0, s1_byte_reg, 3'b000} + {3'b000, s1_byte_reg, 1'b0};
                state_next = ST_DATA;
                emit       = 1'b1;
                res.kind   = KIND_SLOT;
            end
            ST_DATA:
            begin
                if (s1_byte_reg == FESC)
                begin
                    state_next = ST_ESC;
                end
                else if (s1_byte_reg == FEND)
                begin
                    emit        = 1'b1;
                    clear_frame = 1'b1;
                    if (cmd_reg == CMD_DATA && count_reg != '0)
                    begin
                        res.kind         = KIND_COMMIT;
                        res.frame_length = 12'(count_reg);
                    end
                    else
                    begin
                        res.kind = KIND_DISCARD;
                    end
                end
                else if (cmd_reg == CMD_DATA)
                begin
                    if (count_reg < CW'(FRAME_MAX))
                    begin
                        store_en = 1'b1;
                    end
                    else
                    begin
                        emit        = 1'b1;
                        clear_frame = 1'b1;
                        res.kind    = KIND_DISCARD;
                    end
                end
            end
            ST_ESC:
            begin
                state_next = ST_DATA;
                if (count_reg < CW'(FRAME_MAX))
                begin
                    if (s1_byte_reg == TFEND)
                    begin
                        store_en   = 1'b1;
                        store_byte = FEND;
                    end
                    else if (s1_byte_reg == TFESC)
                    begin
                        store_en   = 1'b1;
                        store_byte = FESC;
                    end
                end
            end
            default:
            begin
                if (s1_byte_reg == FEND)
                begin
                    cmd_next   = CMD_NONE;
                    state_next = ST_CMD;
                end
            end
        endcase

        if (clear_frame)
        begin
            count_next    = '0;
            frag_num_next = '0;
            frag_off_next = '0;
            cmd_next      = CMD_NONE;
            state_next    = ST_IDLE;
        end

        // Fragment number and offset follow the count, so no divider is needed.
        if (store_en)
        begin
            emit                = 1'b1;
            res.kind            = KIND_PAYLOAD;
            res.data_byte       = store_byte;
            res.byte_position   = 11'(count_reg);
            res.fragment_number = frag_num_reg;
            res.fragment_offset = frag_off_reg;
            count_next          = count_reg + 1'b1;
            if (frag_off_reg == 8'(FRAGMENT_BYTES - 1))
            begin
                frag_off_next = '0;
                frag_num_next = frag_num_reg + 1'b1;
            end
            else
            begin
                frag_off_next = frag_off_reg + 1'b1;
            end
        end

        res.persistence  = pers_next;
        res.slot_time_ms = slot_next;
    end

    assign advance   = s1_valid_reg && (res_ready || !emit);
    assign in_ready  = !s1_valid_reg || advance;
    assign res_valid = s1_valid_reg && emit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            state_reg    <= ST_IDLE;
            cmd_reg      <= CMD_NONE;
            count_reg    <= '0;
            frag_num_reg <= '0;
            frag_off_reg <= '0;
            pers_reg     <= 8'd255;
            slot_reg     <= '0;
        end
        else
        begin
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (advance)
            begin
                state_reg    <= state_next;
                cmd_reg      <= cmd_next;
                count_reg    <= count_next;
                frag_num_reg <= frag_num_next;
                frag_off_reg <= frag_off_next;
                pers_reg     <= pers_next;
                slot_reg     <= slot_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            s1_byte_reg <= in_byte;
        end
    end

endmodule

// ----- hw/rtl/kdf_out_buf.sv -----
module kdf_out_buf
    import kdf_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  result_t in_res,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_res
);

    logic    out_valid_reg;
    result_t out_res_reg;
    logic    skid_valid_reg;
    result_t skid_res_reg;
    logic    load_out;
    logic    push;

    // The skid stage catches a word when the output register is held.
    assign in_ready  = !skid_valid_reg;
    assign push      = in_valid && in_ready;
    assign load_out  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg  <= skid_valid_reg || push;
            skid_valid_reg <= 1'b0;
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            if (skid_valid_reg)
            begin
                out_res_reg <= skid_res_reg;
            end
            else if (push)
            begin
                out_res_reg <= in_res;
            end
        end
        else if (push)
        begin
            skid_res_reg <= in_res;
        end
    end

endmodule

// ----- bench/kiss_deframer_fragmenter_test.sv -----
module kiss_deframer_fragmenter_test;
    import kdf_pkg::*;

    localparam int FRAME_LIMIT   = DEFAULT_FRAME_MAX;
    localparam int FRAGMENT_SIZE = DEFAULT_FRAGMENT_BYTES;
    localparam int RANDOM_ITEMS  = 550;
    localparam int HOLD_CYCLES   = 300;
    localparam int QUIET_LIMIT   = 4000;
    localparam int TAIL_CYCLES   = 8;

    typedef struct packed {
        logic [7:0] rx;
        logic       pinned;
        result_t    want;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // [7:0] rx_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    // [7:0] data_byte, [18:8] byte_position, [22:19] fragment_number,
    // [30:23] fragment_offset, [42:31] frame_length, [50:43] persistence,
    // [62:51] slot_time_ms, [63] zero
    logic [63:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;   // [2:0] kind

    // Decoder state as the testbench expects it to be.
    logic [2:0]  kiss_state;
    logic [1:0]  kiss_cmd;
    logic [11:0] kiss_count;
    logic [7:0]  kiss_persist;
    logic [11:0] kiss_slot;

    result_t     pending_words[$];
    stim_row_t   directed_rows[$];
    int          word_errors   = 0;
    int          quiet_cycles  = 0;
    int          counted_items = 0;
    bit          steady        = 1'b0;
    bit          hold_req      = 1'b0;

    kiss_deframer_fragmenter uut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int idle_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (steady || roll < 60)
            return 0;
        if (roll < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic string describe(result_t r);
        return $sformatf("kind %0d byte %02h pos %0d frag %0d off %0d len %0d pers %0d slot %0d",
                         r.kind, r.data_byte, r.byte_position, r.fragment_number,
                         r.fragment_offset, r.frame_length, r.persistence, r.slot_time_ms);
    endfunction

    task automatic store_payload(input logic [7:0] value, output result_t r);
        r = '0;
        r.kind            = KIND_PAYLOAD;
        r.data_byte       = value;
        r.byte_position   = kiss_count[10:0];
        r.fragment_number = 4'(kiss_count / FRAGMENT_SIZE);
        r.fragment_offset = 8'(kiss_count % FRAGMENT_SIZE);
        kiss_count        = kiss_count + 12'd1;
    endtask

    task automatic decode_kiss_byte(input logic [7:0] b, output bit produced, output result_t r);
        produced = 1'b0;
        r = '0;
        case (kiss_state)
            ST_CMD:
            begin
                if (b != FEND)
                begin
                    if (b == CMDB_DATA)
                    begin
                        kiss_cmd   = CMD_DATA;
                        kiss_state = ST_DATA;
                    end
                    else if (b == CMDB_PERS)
                    begin
                        kiss_cmd   = CMD_PERS;
                        kiss_state = ST_PERS;
                    end
                    else if (b == CMDB_SLOT)
                    begin
                        kiss_cmd   = CMD_SLOT;
                        kiss_state = ST_SLOT;
                    end
                    else
                    begin
                        kiss_cmd   = CMD_NONE;
                        kiss_state = ST_IDLE;
                    end
                end
            end
            ST_PERS:
            begin
                kiss_persist = b;
                kiss_state   = ST_DATA;
                r.kind       = KIND_PERS;
                produced     = 1'b1;
            end
            ST_SLOT:
            begin
                kiss_slot  = b * 12'd10;
                kiss_state = ST_DATA;
                r.kind     = KIND_SLOT;
                produced   = 1'b1;
            end
            ST_DATA:
            begin
                if (b == FESC)
                    kiss_state = ST_ESC;
                else if (b == FEND)
                begin
                    produced = 1'b1;
                    if (kiss_cmd == CMD_DATA && kiss_count != 12'd0)
                    begin
                        r.kind         = KIND_COMMIT;
                        r.frame_length = kiss_count;
                    end
                    else
                        r.kind = KIND_DISCARD;
                    kiss_count = 12'd0;
                    kiss_cmd   = CMD_NONE;
                    kiss_state = ST_IDLE;
                end
                else if (kiss_cmd == CMD_DATA)
                begin
                    produced = 1'b1;
                    if (kiss_count < FRAME_LIMIT)
                        store_payload(b, r);
                    else
                    begin
                        // A byte beyond the frame limit throws the whole frame away.
                        r.kind     = KIND_DISCARD;
                        kiss_count = 12'd0;
                        kiss_cmd   = CMD_NONE;
                        kiss_state = ST_IDLE;
                    end
                end
            end
            ST_ESC:
            begin
                // Valid escapes are kept whatever the frame's command, but not past the limit.
                kiss_state = ST_DATA;
                if (kiss_count < FRAME_LIMIT)
                begin
                    if (b == TFEND)
                    begin
                        store_payload(FEND, r);
                        produced = 1'b1;
                    end
                    else if (b == TFESC)
                    begin
                        store_payload(FESC, r);
                        produced = 1'b1;
                    end
                end
            end
            default:
            begin
                if (b == FEND)
                begin
                    kiss_cmd   = CMD_NONE;
                    kiss_state = ST_CMD;
                end
            end
        endcase
        if (produced)
        begin
            r.persistence  = kiss_persist;
            r.slot_time_ms = kiss_slot;
        end
    endtask

    // Offers one byte, waits for it to be taken and records what it should cause.
    task automatic send_byte(input logic [7:0] b, input logic pinned, input result_t want);
        int      gap;
        bit      produced;
        result_t r;
        gap = idle_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        if (kiss_state != ST_IDLE || b == FEND)
            counted_items++;
        decode_kiss_byte(b, produced, r);
        if (pinned)
            pending_words.push_back(want);
        else if (produced)
            pending_words.push_back(r);
    endtask

    task automatic send(input logic [7:0] b);
        send_byte(b, 1'b0, '0);
    endtask

    task automatic add_row(input logic [7:0] b);
        stim_row_t row;
        row = '0;
        row.rx = b;
        directed_rows.push_back(row);
    endtask

    task automatic add_pin(input logic [7:0] b, input logic [2:0] kind, input logic [11:0] len,
                           input logic [7:0] pers, input logic [11:0] slot);
        stim_row_t row;
        row = '0;
        row.rx                = b;
        row.pinned            = 1'b1;
        row.want.kind         = kind;
        row.want.frame_length = len;
        row.want.persistence  = pers;
        row.want.slot_time_ms = slot;
        directed_rows.push_back(row);
    endtask

    task automatic send_data_frame(input int len);
        int roll;
        send(FEND);
        if ($urandom_range(0, 7) == 0)
            send(FEND);
        send(CMDB_DATA);
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                send(FESC);
                roll = $urandom_range(0, 5);
                if (roll < 2)
                    send(TFEND);
                else if (roll < 4)
                    send(TFESC);
                else
                    send(8'($urandom_range(0, 255)));
            end
            else
                send(8'($urandom_range(0, 255)));
        end
        if ($urandom_range(0, 9) != 0)
            send(FEND);
    endtask

    task automatic send_setting_frame(input logic [7:0] cmd);
        send(FEND);
        send(cmd);
        send(8'($urandom_range(0, 255)));
        repeat ($urandom_range(0, 2)) send(8'($urandom_range(0, 255)));
        if ($urandom_range(0, 9) != 0)
            send(FEND);
    endtask

    task automatic send_full_frame(input bit overflow);
        logic [7:0] b;
        send(FEND);
        send(CMDB_DATA);
        for (int i = 0; i < FRAME_LIMIT; i++)
        begin
            b = 8'($urandom_range(0, 255));
            if (b == FEND || b == FESC)
                b = ~b;
            send(b);
        end
        if (overflow)
            send(8'h5A);
        else
        begin
            // The escaped byte lands past the limit and is dropped.
            send(FESC);
            send(TFEND);
            send(FEND);
        end
    endtask

    task automatic pause_until_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_words.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin : result_sink
        int      stall_left;
        result_t got;
        result_t want;
        stall_left    = 0;
        m_axis_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_axis_tvalid && m_axis_tready)
            begin
                got                 = '0;
                got.kind            = m_axis_tuser;
                got.data_byte       = m_axis_tdata[7:0];
                got.byte_position   = m_axis_tdata[18:8];
                got.fragment_number = m_axis_tdata[22:19];
                got.fragment_offset = m_axis_tdata[30:23];
                got.frame_length    = m_axis_tdata[42:31];
                got.persistence     = m_axis_tdata[50:43];
                got.slot_time_ms    = m_axis_tdata[62:51];
                if (pending_words.size() == 0)
                begin
                    word_errors++;
                    if (word_errors <= 10)
                        $display("unexpected result word: %s", describe(got));
                end
                else
                begin
                    want = pending_words.pop_front();
                    if (got !== want)
                    begin
                        word_errors++;
                        if (word_errors <= 10)
                            $display("result word mismatch: expected %s, got %s",
                                     describe(want), describe(got));
                    end
                end
            end
            if (hold_req)
            begin
                hold_req   = 1'b0;
                stall_left = HOLD_CYCLES;
            end
            else if (stall_left == 0 && !steady && $urandom_range(0, 4) == 0)
                stall_left = idle_gap();
            if (stall_left > 0)
            begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin : stimulus
        int roll;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 8'h00;
        kiss_state    = ST_IDLE;
        kiss_cmd      = CMD_NONE;
        kiss_count    = 12'd0;
        kiss_persist  = 8'd255;
        kiss_slot     = 12'd0;

        // A persistence frame, with stray and escaped bytes, closed by a discard.
        add_row(8'h55);
        add_row(FEND);
        add_row(FEND);
        add_row(CMDB_PERS);
        add_pin(8'h00, KIND_PERS, 12'd0, 8'd0, 12'd0);
        add_row(8'h41);
        add_row(FESC);
        add_row(TFEND);
        add_pin(FEND, KIND_DISCARD, 12'd0, 8'd0, 12'd0);
        // Largest slot time.
        add_row(FEND);
        add_row(CMDB_SLOT);
        add_pin(8'hFF, KIND_SLOT, 12'd0, 8'd0, 12'd2550);
        add_pin(FEND, KIND_DISCARD, 12'd0, 8'd0, 12'd2550);
        // Data frame with one valid and one invalid escape.
        add_row(FEND);
        add_row(CMDB_DATA);
        add_row(8'h00);
        add_row(8'hFF);
        add_row(FESC);
        add_row(TFESC);
        add_row(FESC);
        add_row(8'h12);
        add_pin(FEND, KIND_COMMIT, 12'd3, 8'd0, 12'd2550);
        // An empty data frame is discarded.
        add_row(FEND);
        add_row(CMDB_DATA);
        add_pin(FEND, KIND_DISCARD, 12'd0, 8'd0, 12'd2550);
        // Unknown command drops back to idle.
        add_row(FEND);
        add_row(8'h07);
        add_row(8'h11);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_byte(directed_rows[i].rx, directed_rows[i].pinned, directed_rows[i].want);

        // Hold the output off while words keep coming, so that the input stalls.
        hold_req = 1'b1;
        steady   = 1'b1;
        send_data_frame(40);
        steady   = 1'b0;
        pause_until_drained();

        counted_items = 0;
        while (counted_items < RANDOM_ITEMS)
        begin
            steady = ($urandom_range(0, 7) == 0);
            roll   = $urandom_range(0, 99);
            if (roll < 55)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 85)
                    send_data_frame($urandom_range(0, 24));
                else if (roll < 97)
                    send_data_frame($urandom_range(25, 120));
                else
                    send_data_frame($urandom_range(150, 420));
            end
            else if (roll < 67)
                send_setting_frame(CMDB_PERS);
            else if (roll < 79)
                send_setting_frame(CMDB_SLOT);
            else if (roll < 87)
            begin
                send(FEND);
                repeat ($urandom_range(1, 4)) send(8'($urandom_range(0, 255)));
            end
            else
                repeat ($urandom_range(1, 4)) send(8'($urandom_range(0, 255)));
            if ($urandom_range(0, 39) == 0)
                pause_until_drained();
            if ($urandom_range(0, 49) == 0)
                hold_req = 1'b1;
        end
        steady = 1'b0;

        // Bring the parser back to idle before the two full-length frames.
        while (kiss_state != ST_IDLE)
        begin
            if (kiss_state == ST_CMD)
                send(8'h55);
            else
                send(FEND);
        end
        send_full_frame(1'b0);
        send_full_frame(1'b1);

        s_axis_tvalid <= 1'b0;
        while (pending_words.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (word_errors == 0 && pending_words.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
